>>> rtl/assert_macros.svh
// Assertion macros shared by the list store RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent holds -> consequent holds in the same cycle.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Antecedent holds -> consequent holds in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/plist_pkg.sv
// Types and constants for the positional list store.
// No dependencies.
package plist_pkg;

  localparam int DEPTH  = 64;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int POS_W  = 7;
  localparam int CMP_W  = (POS_W > IDX_W + 1) ? POS_W : IDX_W + 1;
  localparam int DATA_W = 32;
  localparam int OP_W   = 3;
  localparam int ST_W   = 2;
  localparam int OCNT_W = 7;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_REMOVE = 3'd1,
    OP_GET    = 3'd2,
    OP_SET    = 3'd3,
    OP_CLEAR  = 3'd4
  } opcode_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_SET
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t          cmd;
    logic [CMP_W-1:0]   pos;
    logic [DATA_W-1:0]  value;
  } cell_ctl_t;

endpackage

>>> rtl/plist_cell.sv
// One slot of the list: holds a value, shifts from a neighbor or loads new data.
// Depends on plist_pkg.
module plist_cell (
  input  logic                           clk,
  input  plist_pkg::cell_ctl_t           ctl,
  input  logic [plist_pkg::CMP_W-1:0]    idx,
  input  logic [plist_pkg::DATA_W-1:0]   left_val,
  input  logic [plist_pkg::DATA_W-1:0]   right_val,
  output logic [plist_pkg::DATA_W-1:0]   val,
  output logic [plist_pkg::DATA_W-1:0]   rd_part
);

  logic [plist_pkg::DATA_W-1:0] val_next;
  logic                         hit;
  logic                         above;

  assign hit   = (idx == ctl.pos);
  assign above = (idx > ctl.pos);

  always_comb begin
    val_next = val;
    case (ctl.cmd)
      plist_pkg::CELL_INSERT: begin
        if (hit) begin
          val_next = ctl.value;
        end else if (above) begin
          val_next = left_val;
        end
      end
      plist_pkg::CELL_REMOVE: begin
        if (hit || above) begin
          val_next = right_val;
        end
      end
      plist_pkg::CELL_SET: begin
        if (hit) begin
          val_next = ctl.value;
        end
      end
      default: val_next = val;
    endcase
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

  assign rd_part = hit ? val : '0;

endmodule

>>> rtl/positional_list_store.sv
// Top level of the positional list store: decode, count, cell row, result register.
// Depends on plist_pkg, plist_cell and assert_macros.svh.
//
// An ordered list of signed 32-bit entries held in a row of DEPTH cells. Every
// operation (insert, remove, get, set, clear) is done at the input transfer: all
// cells compare their index with the position and shift, load or hold at once,
// and the result is registered for the output channel. A new item is taken
// every cycle as long as the result register is free or being drained. Get
// reads through an OR of the per-cell hit outputs. Entries past the count are
// never read; errors leave the list unchanged.
`include "assert_macros.svh"

module positional_list_store (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [plist_pkg::OP_W-1:0]        opcode,
  input  logic [plist_pkg::POS_W-1:0]       position,
  input  logic signed [plist_pkg::DATA_W-1:0] value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [plist_pkg::DATA_W-1:0] read_value,
  output logic [plist_pkg::ST_W-1:0]        status,
  output logic [plist_pkg::OCNT_W-1:0]      count,
  output logic                              is_empty
);

  localparam int CMP_W  = plist_pkg::CMP_W;
  localparam int DATA_W = plist_pkg::DATA_W;
  localparam int DEPTH  = plist_pkg::DEPTH;

  logic [plist_pkg::CNT_W-1:0] cnt;
  logic [plist_pkg::CNT_W-1:0] cnt_next;
  logic                        accept;
  logic [CMP_W-1:0]            pos_ext;
  logic [CMP_W-1:0]            cnt_ext;
  logic [CMP_W-1:0]            cnt_next_ext;
  plist_pkg::status_t          st_next;
  plist_pkg::cell_ctl_t        ctl;
  logic [DATA_W-1:0]           rd_or;
  logic [DATA_W-1:0]           rd_next;

  logic [DATA_W-1:0] cell_val [DEPTH];
  logic [DATA_W-1:0] cell_rd  [DEPTH];

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign pos_ext  = CMP_W'(position);
  assign cnt_ext  = CMP_W'(cnt);

  always_comb begin
    rd_or = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_or = rd_or | cell_rd[i];
    end
  end

  always_comb begin
    cnt_next  = cnt;
    st_next   = plist_pkg::ST_OK;
    rd_next   = '0;
    ctl.cmd   = plist_pkg::CELL_HOLD;
    ctl.pos   = pos_ext;
    ctl.value = value;
    case (opcode)
      plist_pkg::OP_INSERT: begin
        if (pos_ext > cnt_ext) begin
          st_next = plist_pkg::ST_BAD_POS;
        end else if (cnt_ext == CMP_W'(DEPTH)) begin
          st_next = plist_pkg::ST_FULL;
        end else begin
          ctl.cmd  = plist_pkg::CELL_INSERT;
          cnt_next = cnt + 1'b1;
        end
      end
      plist_pkg::OP_REMOVE: begin
        if (pos_ext >= cnt_ext) begin
          st_next = plist_pkg::ST_BAD_POS;
        end else begin
          ctl.cmd  = plist_pkg::CELL_REMOVE;
          cnt_next = cnt - 1'b1;
        end
      end
      plist_pkg::OP_GET: begin
        if (pos_ext >= cnt_ext) begin
          st_next = plist_pkg::ST_BAD_POS;
        end else begin
          rd_next = rd_or;
        end
      end
      plist_pkg::OP_SET: begin
        if (pos_ext >= cnt_ext) begin
          st_next = plist_pkg::ST_BAD_POS;
        end else begin
          ctl.cmd = plist_pkg::CELL_SET;
        end
      end
      plist_pkg::OP_CLEAR: begin
        cnt_next = '0;
      end
      default: st_next = plist_pkg::ST_BAD_POS;
    endcase
    if (!accept) begin
      ctl.cmd  = plist_pkg::CELL_HOLD;
      cnt_next = cnt;
    end
  end

  assign cnt_next_ext = CMP_W'(cnt_next);

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_W-1:0] left_val;
    logic [DATA_W-1:0] right_val;
    if (g == 0) begin : g_first
      assign left_val = '0;
    end else begin : g_left
      assign left_val = cell_val[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_val = '0;
    end else begin : g_right
      assign right_val = cell_val[g+1];
    end
    plist_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .idx       (CMP_W'(g)),
      .left_val  (left_val),
      .right_val (right_val),
      .val       (cell_val[g]),
      .rd_part   (cell_rd[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      cnt <= cnt_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      read_value <= rd_next;
      status     <= st_next;
      count      <= cnt_next_ext[plist_pkg::OCNT_W-1:0];
      is_empty   <= (cnt_next == '0);
    end
  end

  `ASSERT_SAME(a_cnt_range, clk, rst, 1'b1, cnt_ext <= CMP_W'(DEPTH))
  `ASSERT_NEXT(a_clear_empties, clk, rst,
    accept && opcode == plist_pkg::OP_CLEAR, cnt == '0)
  `ASSERT_NEXT(a_error_holds, clk, rst,
    accept && st_next != plist_pkg::ST_OK, cnt == $past(cnt))
  `ASSERT_NEXT(a_result_loaded, clk, rst,
    accept, out_valid && is_empty == (cnt == '0))

endmodule

>>> verif/list_store_checker.sv
// Checker for positional_list_store: watches both channels, predicts each result and compares.
// Depends on plist_pkg for widths, opcodes and status codes.
`timescale 1ns / 100ps

module list_store_checker
  import plist_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic [OP_W-1:0]          opcode,
  input  logic [POS_W-1:0]         position,
  input  logic signed [DATA_W-1:0] value,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic signed [DATA_W-1:0] read_value,
  input  logic [ST_W-1:0]          status,
  input  logic [OCNT_W-1:0]        count,
  input  logic                     is_empty,
  output int                       errors,
  output int                       outstanding,
  output int                       list_len
);

  typedef struct {
    logic signed [DATA_W-1:0] rd;
    status_t                  st;
    logic [OCNT_W-1:0]        cnt;
    logic                     empty;
  } list_result_t;

  logic signed [DATA_W-1:0] entries [DEPTH];
  int                       entry_total = 0;
  list_result_t             result_q [$];

  function automatic list_result_t apply_op(input logic [OP_W-1:0] op,
                                            input logic [POS_W-1:0] pos,
                                            input logic signed [DATA_W-1:0] val);
    list_result_t r;
    int           p;
    r.rd = '0;
    r.st = ST_OK;
    p    = int'(pos);
    case (op)
      OP_INSERT: begin
        if (p > entry_total) r.st = ST_BAD_POS;
        else if (entry_total >= DEPTH) r.st = ST_FULL;
        else begin
          for (int i = entry_total; i > p; i--) entries[i] = entries[i-1];
          entries[p] = val;
          entry_total++;
        end
      end
      OP_REMOVE: begin
        if (p >= entry_total) r.st = ST_BAD_POS;
        else begin
          for (int i = p; i + 1 < entry_total; i++) entries[i] = entries[i+1];
          entry_total--;
        end
      end
      OP_GET: begin
        if (p >= entry_total) r.st = ST_BAD_POS;
        else r.rd = entries[p];
      end
      OP_SET: begin
        if (p >= entry_total) r.st = ST_BAD_POS;
        else entries[p] = val;
      end
      OP_CLEAR: entry_total = 0;
      default: r.st = ST_BAD_POS;
    endcase
    r.cnt   = entry_total[OCNT_W-1:0];
    r.empty = (entry_total == 0);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    list_result_t exp;
    if (rst) begin
      result_q.delete();
      entry_total = 0;
    end else begin
      if (in_valid && in_ready) result_q.push_back(apply_op(opcode, position, value));
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          $error("result transfer with no pending expectation");
          errors++;
        end else begin
          exp = result_q.pop_front();
          if (read_value !== exp.rd) begin
            $error("read_value: expected %0d, got %0d", exp.rd, read_value);
            errors++;
          end
          if (status !== exp.st) begin
            $error("status: expected %0d, got %0d", exp.st, status);
            errors++;
          end
          if (count !== exp.cnt) begin
            $error("count: expected %0d, got %0d", exp.cnt, count);
            errors++;
          end
          if (is_empty !== exp.empty) begin
            $error("is_empty: expected %0d, got %0d", exp.empty, is_empty);
            errors++;
          end
        end
      end
    end
    outstanding = result_q.size();
    list_len    = entry_total;
  end

endmodule

>>> verif/tb_positional_list_store.sv
// Testbench top for positional_list_store: clock, reset, stimulus, back-pressure and verdict.
// Depends on plist_pkg, the block and list_store_checker.
`timescale 1ns / 100ps

module tb_positional_list_store;
  import plist_pkg::*;

  localparam logic [OP_W-1:0] OP_ILLEGAL_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_ILLEGAL_MID   = 3'd6;
  localparam logic [OP_W-1:0] OP_ILLEGAL_LAST  = 3'd7;
  localparam int              CYCLE_LIMIT      = 200_000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_ready;
  logic [OP_W-1:0]          opcode;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] value;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [DATA_W-1:0] read_value;
  logic [ST_W-1:0]          status;
  logic [OCNT_W-1:0]        count;
  logic                     is_empty;

  int errors;
  int outstanding;
  int list_len;
  int idle_pct;
  int cycle_count;

  positional_list_store DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .position(position), .value(value),
    .out_valid(out_valid), .out_ready(out_ready),
    .read_value(read_value), .status(status), .count(count), .is_empty(is_empty)
  );

  list_store_checker CHK (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .position(position), .value(value),
    .out_valid(out_valid), .out_ready(out_ready),
    .read_value(read_value), .status(status), .count(count), .is_empty(is_empty),
    .errors(errors), .outstanding(outstanding), .list_len(list_len)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** positional_list_store: FAILED **");
    $finish;
  end

  // result side: random stall bursts
  initial begin : drain
    int stall_left;
    stall_left = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (idle_pct > 0 && $urandom_range(0, 199) < idle_pct) begin
        stall_left = $urandom_range(1, 5) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_item(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                           input logic signed [DATA_W-1:0] val);
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    position <= pos;
    value    <= val;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain_all();
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
  endtask

  task automatic random_item(input int ins_w, input int rem_w, input int clr_w);
    int               roll;
    int               len;
    logic [OP_W-1:0]  op;
    logic [POS_W-1:0] pos;
    roll = $urandom_range(0, 99);
    len  = list_len;
    if (roll < ins_w) op = OP_INSERT;
    else if (roll < ins_w + rem_w) op = OP_REMOVE;
    else if (roll < ins_w + rem_w + clr_w) op = OP_CLEAR;
    else if (roll < 97) op = $urandom_range(0, 1) ? OP_GET : OP_SET;
    else op = OP_W'($urandom_range(OP_ILLEGAL_FIRST, OP_ILLEGAL_LAST));
    if ($urandom_range(0, 9) == 0) pos = POS_W'($urandom_range(0, (1 << POS_W) - 1));
    else if (op == OP_INSERT) pos = POS_W'($urandom_range(0, len));
    else if (len > 0) pos = POS_W'($urandom_range(0, len - 1));
    else pos = POS_W'($urandom_range(0, 1));
    send_item(op, pos, pick_value());
  endtask

  task automatic run_phase(input int n, input int ins_w, input int rem_w, input int clr_w,
                           input int idle);
    idle_pct = idle;
    repeat (n) random_item(ins_w, rem_w, clr_w);
  endtask

  initial begin
    idle_pct = 0;
    rst      = 1'b1;
    in_valid = 1'b0;
    opcode   = OP_CLEAR;
    position = '0;
    value    = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty list errors, single-entry removal, edges of value and position
    idle_pct = 20;
    send_item(OP_GET,    0, 0);
    send_item(OP_REMOVE, 0, 0);
    send_item(OP_SET,    0, VAL_MAX);
    send_item(OP_INSERT, 1, 7);
    send_item(OP_INSERT, 127, 7);
    send_item(OP_INSERT, 0, VAL_MAX);
    send_item(OP_REMOVE, 0, 0);
    send_item(OP_INSERT, 0, VAL_MIN);
    send_item(OP_INSERT, 1, -1);
    send_item(OP_INSERT, 0, 5);
    send_item(OP_INSERT, 1, 123);
    send_item(OP_GET,    0, 0);
    send_item(OP_GET,    1, 0);
    send_item(OP_GET,    3, 0);
    send_item(OP_GET,    4, 0);
    send_item(OP_SET,    2, VAL_MAX);
    send_item(OP_SET,    4, 9);
    send_item(OP_GET,    2, 0);
    send_item(OP_REMOVE, 1, 0);
    send_item(OP_REMOVE, 5, 0);
    send_item(OP_CLEAR,  127, VAL_MIN);
    send_item(OP_GET,    0, 0);
    send_item(OP_ILLEGAL_FIRST, 127, VAL_MAX);
    send_item(OP_ILLEGAL_MID,   0, 0);
    send_item(OP_ILLEGAL_LAST,  64, -1);

    run_phase(300, 70, 10, 0, 20);   // fills up, then hits the full-list insert
    drain_all();
    run_phase(250, 15, 60, 0, 30);
    run_phase(150, 35, 30, 2, 0);
    run_phase(300, 35, 30, 2, 40);
    drain_all();
    run_phase(200, 70, 5, 0, 10);
    run_phase(200, 35, 30, 2, 0);

    drain_all();
    repeat (10) @(negedge clk);
    if (errors == 0) $display("** positional_list_store: PASSED **");
    else $display("** positional_list_store: FAILED **");
    $finish;
  end

endmodule
